// ===== rtl/core/wlfc_pkg.sv =====
// Shared types, constants and a helper function of the water level fill control.
package wlfc_pkg;

  // Width of the tick counters.
  localparam int COUNT_WIDTH = 16;

  // Width of every tick limit register as seen on the configuration port.
  localparam int LIMIT_WIDTH = 16;

  // Number of fault bits in one tick.
  localparam int FAULT_WIDTH = 5;

  // Configuration register indexes.
  localparam int CFG_INDEX_WIDTH = 3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DETECT_TICKS        = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNDETECT_TICKS      = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TOPUP_TICKS         = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INITIAL_FILL_TICKS  = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INITIAL_FILL_ENABLE = 3'd4;

  // Register values after reset.
  localparam logic [LIMIT_WIDTH-1:0] DETECT_TICKS_RESET       = 16'd200;
  localparam logic [LIMIT_WIDTH-1:0] UNDETECT_TICKS_RESET     = 16'd200;
  localparam logic [LIMIT_WIDTH-1:0] TOPUP_TICKS_RESET        = 16'd500;
  localparam logic [LIMIT_WIDTH-1:0] INITIAL_FILL_TICKS_RESET = 16'd2500;

  // All fault bits set: the level actions are skipped.
  localparam logic [FAULT_WIDTH-1:0] ALL_FAULTS = '1;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [LIMIT_WIDTH-1:0] limit_t;

  // One input tick.
  typedef struct packed {
    logic                   power_on;
    logic                   motor_starting;
    logic                   sensor_wet;
    logic [FAULT_WIDTH-1:0] fault_flags;
    logic                   setting_idle;
    logic                   memento_shown;
    logic                   wash_mode;
    logic                   motors_home;
    logic                   sterilizing;
    logic                   nozzle_cleaning;
    logic                   factory_running;
    logic                   stop_error;
  } in_item_t;

  // One result per tick.
  typedef struct packed {
    logic valve_open;
    logic level_present;
    logic request_wash_stop;
    logic request_homing;
    logic electrolysis_stop;
    logic initial_fill_done;
  } out_item_t;

  // Configuration seen by the fill logic, with the pulse that clears the
  // finished flag of the forced fill.
  typedef struct packed {
    limit_t detect_ticks;
    limit_t undetect_ticks;
    limit_t topup_ticks;
    limit_t initial_fill_ticks;
    logic   initial_fill_enable;
    logic   initial_fill_clear;
  } cfg_t;

  // Saturate a tick limit to the largest counter value.
  function automatic count_t lim(input limit_t v);
    logic [63:0] v64;
    logic [63:0] max64;
    v64   = 64'(v);
    max64 = (64'd1 << COUNT_WIDTH) - 64'd1;
    if (v64 > max64) begin
      return max64[COUNT_WIDTH-1:0];
    end
    return v64[COUNT_WIDTH-1:0];
  endfunction

endpackage

// ===== rtl/core/wlfc_chan_if.sv =====
// Valid/ready channel interfaces for input ticks and results.
interface wlfc_in_if import wlfc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wlfc_out_if import wlfc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/water_level_fill_control.sv =====
// Top level of the water level fill control: input register, fill logic, result register.
//
// Each transfer on in_chan is one 10 ms tick and yields exactly one result on
// out_chan. A tick is captured in an input register, evaluated against the fill
// state combinationally, and its result is held in an output register, so a new
// tick is accepted in every cycle while out_chan takes its results. When
// out_chan stalls the output register holds and the input register takes at
// most one more tick before in_chan.ready drops. Configuration writes on
// cfg_we/cfg_index/cfg_wdata take effect at the next clock edge and are to be
// made only while no tick is in flight; writing the initial fill enable
// register also owes a fresh forced fill.
module water_level_fill_control import wlfc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  wlfc_in_if.sink                    in_chan,
  wlfc_out_if.source                 out_chan,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [LIMIT_WIDTH-1:0]     cfg_wdata
);

  cfg_t      cfg;
  in_item_t  in_data_r;
  logic      in_valid_r;
  out_item_t out_data_r;
  logic      out_valid_r;
  out_item_t result;
  logic      advance;
  logic      step;

  wlfc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  wlfc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_data_r),
    .cfg    (cfg),
    .result (result)
  );

  // The pipeline moves when the output register is free or being emptied.
  assign advance       = !out_valid_r || out_chan.ready;
  assign step          = in_valid_r && advance;
  assign in_chan.ready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_data_r <= in_chan.data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= result;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

endmodule

// ===== rtl/core/wlfc_cfg.sv =====
// Configuration register file of the water level fill control.
module wlfc_cfg import wlfc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [LIMIT_WIDTH-1:0]     cfg_wdata,
  output cfg_t                       cfg
);

  limit_t detect_ticks_r;
  limit_t undetect_ticks_r;
  limit_t topup_ticks_r;
  limit_t initial_fill_ticks_r;
  logic   initial_fill_enable_r;

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      detect_ticks_r        <= DETECT_TICKS_RESET;
      undetect_ticks_r      <= UNDETECT_TICKS_RESET;
      topup_ticks_r         <= TOPUP_TICKS_RESET;
      initial_fill_ticks_r  <= INITIAL_FILL_TICKS_RESET;
      initial_fill_enable_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DETECT_TICKS:        detect_ticks_r        <= cfg_wdata;
        CFG_UNDETECT_TICKS:      undetect_ticks_r      <= cfg_wdata;
        CFG_TOPUP_TICKS:         topup_ticks_r         <= cfg_wdata;
        CFG_INITIAL_FILL_TICKS:  initial_fill_ticks_r  <= cfg_wdata;
        CFG_INITIAL_FILL_ENABLE: initial_fill_enable_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // A write of the enable register owes a fresh forced fill.
  always_comb begin
    cfg.detect_ticks        = detect_ticks_r;
    cfg.undetect_ticks      = undetect_ticks_r;
    cfg.topup_ticks         = topup_ticks_r;
    cfg.initial_fill_ticks  = initial_fill_ticks_r;
    cfg.initial_fill_enable = initial_fill_enable_r;
    cfg.initial_fill_clear  = cfg_we && (cfg_index == CFG_INITIAL_FILL_ENABLE);
  end

endmodule

// ===== rtl/core/wlfc_core.sv =====
// Per-tick fill state and the combinational logic that advances it.
module wlfc_core import wlfc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  logic   level_r, level_nxt;
  count_t wet_count_r, wet_count_nxt;
  count_t dry_count_r, dry_count_nxt;
  logic   topup_armed_r, topup_armed_nxt;
  count_t topup_remaining_r, topup_remaining_nxt;
  logic   init_finished_r, init_finished_nxt;
  logic   init_active_r, init_active_nxt;
  count_t init_elapsed_r, init_elapsed_nxt;
  logic   owed;

  // Next state and result of the tick held in the input register.
  always_comb begin
    level_nxt           = level_r;
    wet_count_nxt       = wet_count_r;
    dry_count_nxt       = dry_count_r;
    topup_armed_nxt     = topup_armed_r;
    topup_remaining_nxt = topup_remaining_r;
    init_finished_nxt   = init_finished_r;
    init_active_nxt     = init_active_r;
    init_elapsed_nxt    = init_elapsed_r;
    result              = '0;
    owed                = cfg.initial_fill_enable && !init_finished_r;

    if (item.power_on) begin
      if (item.motor_starting) begin
        // Arm the forced fill while a motor starts up.
        if (owed) begin
          init_active_nxt = 1'b1;
        end
      end else if (init_active_r) begin
        // Forced fill: hold the valve open for the configured length.
        if (init_elapsed_r < lim(cfg.initial_fill_ticks)) begin
          init_elapsed_nxt  = init_elapsed_r + count_t'(1);
          result.valve_open = 1'b1;
        end else begin
          init_finished_nxt        = 1'b1;
          result.initial_fill_done = 1'b1;
          init_active_nxt          = 1'b0;
          init_elapsed_nxt         = '0;
        end
      end else begin
        // Top-up countdown.
        if (topup_remaining_r != '0) begin
          topup_remaining_nxt = topup_remaining_r - count_t'(1);
          result.valve_open   = 1'b1;
        end

        // Debounce of the level switch.
        if (item.sensor_wet) begin
          dry_count_nxt = '0;
          if (wet_count_r < lim(cfg.detect_ticks)) begin
            wet_count_nxt = wet_count_r + count_t'(1);
          end else begin
            level_nxt = 1'b1;
          end
        end else begin
          wet_count_nxt = '0;
          if (dry_count_r < lim(cfg.undetect_ticks)) begin
            dry_count_nxt = dry_count_r + count_t'(1);
          end else begin
            level_nxt = 1'b0;
          end
        end

        // Level actions, skipped only when every fault bit is set.
        if (item.fault_flags != ALL_FAULTS) begin
          if (level_nxt) begin
            if (topup_armed_r && item.setting_idle && !item.memento_shown) begin
              topup_armed_nxt = 1'b0;
              if (topup_remaining_nxt == '0) begin
                topup_remaining_nxt = lim(cfg.topup_ticks);
              end
            end
          end else begin
            if (item.wash_mode) begin
              result.request_wash_stop = 1'b1;
            end else begin
              if (!topup_armed_r) begin
                result.request_homing = 1'b1;
              end
              if (item.motors_home && !item.sterilizing && !item.nozzle_cleaning &&
                  topup_remaining_nxt == '0 && !item.memento_shown &&
                  !item.factory_running && !item.stop_error) begin
                result.valve_open = 1'b1;
              end
            end
            result.electrolysis_stop = 1'b1;
            topup_armed_nxt          = 1'b1;
          end
        end
      end
    end

    result.level_present = level_nxt;
  end

  // State registers advance once per transfer out of the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r           <= 1'b0;
      wet_count_r       <= '0;
      dry_count_r       <= '0;
      topup_armed_r     <= 1'b0;
      topup_remaining_r <= lim(TOPUP_TICKS_RESET);
      init_finished_r   <= 1'b0;
      init_active_r     <= 1'b0;
      init_elapsed_r    <= '0;
    end else begin
      if (step) begin
        level_r           <= level_nxt;
        wet_count_r       <= wet_count_nxt;
        dry_count_r       <= dry_count_nxt;
        topup_armed_r     <= topup_armed_nxt;
        topup_remaining_r <= topup_remaining_nxt;
        init_active_r     <= init_active_nxt;
        init_elapsed_r    <= init_elapsed_nxt;
      end
      if (cfg.initial_fill_clear) begin
        init_finished_r <= 1'b0;
      end else if (step) begin
        init_finished_r <= init_finished_nxt;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // The debounce counters never run at the same time.
  a_counts_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(wet_count_r != '0 && dry_count_r != '0))
    else $error("wet and dry counters both nonzero");

  // The forced-fill timer only runs while the forced fill is active.
  a_elapsed_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !init_active_r |-> init_elapsed_r == '0)
    else $error("forced-fill timer nonzero while inactive");

  // The end of the forced fill leaves it inactive and finished.
  a_done_ends_fill: assert property (@(posedge clk) disable iff (!rst_n)
    step && result.initial_fill_done && !cfg.initial_fill_clear |=>
      !init_active_r && init_finished_r)
    else $error("forced fill still active after its done pulse");

  // A tick with power off leaves the level, the wet count and the top-up countdown untouched.
  a_power_off_holds: assert property (@(posedge clk) disable iff (!rst_n)
    step && !item.power_on |=>
      level_r == $past(level_r) && wet_count_r == $past(wet_count_r) &&
      topup_remaining_r == $past(topup_remaining_r))
    else $error("state changed on a power-off tick");

  // A wash stop always comes with an electrolysis stop.
  a_wash_stop_ew: assert property (@(posedge clk) disable iff (!rst_n)
    step && result.request_wash_stop |-> result.electrolysis_stop)
    else $error("wash stop without electrolysis stop");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench of the water level fill control: predicts every tick result and compares it.
module testbench;
  import wlfc_pkg::*;

  // Writes to this index land on no register and must leave the block unchanged.
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_INDEX = 3'd7;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 150;

  typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_PERIODIC, RX_COIN} rx_mode_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [LIMIT_WIDTH-1:0] cfg_wdata;

  wlfc_in_if in_ch ();
  wlfc_out_if out_ch ();

  water_level_fill_control dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_ch),
    .out_chan(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Predicted copy of the registers.
  limit_t detect_lim;
  limit_t undetect_lim;
  limit_t topup_len;
  limit_t first_fill_len;
  logic first_fill_en;

  // Predicted copy of the fill state.
  logic level_q;
  count_t wet_run;
  count_t dry_run;
  logic topup_pending;
  count_t topup_left;
  logic first_fill_finished;
  logic first_fill_active;
  count_t first_fill_elapsed;

  // Results owed by the block, oldest first.
  out_item_t fill_results_due[$];
  out_item_t want;
  int fail_count;
  int stall_cycles;

  // Sender pacing and random stimulus knobs.
  logic pace_sender;
  int burst_left;
  int motor_odds;
  int sensor_run_max;
  logic sensor_now;
  int sensor_run_left;

  // Receiver pattern state.
  rx_mode_t rx_mode;
  int rx_cycle;
  int hold_left;
  logic hold_request;

  always #4 clk = ~clk;

  // A limit wider than the counters is clipped to the largest count.
  function automatic count_t cap_limit(input limit_t v);
    if ($bits(limit_t) > $bits(count_t) && 64'(v) > 64'(count_t'('1))) begin
      return '1;
    end
    return count_t'(v);
  endfunction

  function automatic void reset_fill_state();
    detect_lim = DETECT_TICKS_RESET;
    undetect_lim = UNDETECT_TICKS_RESET;
    topup_len = TOPUP_TICKS_RESET;
    first_fill_len = INITIAL_FILL_TICKS_RESET;
    first_fill_en = 1'b0;
    level_q = 1'b0;
    wet_run = '0;
    dry_run = '0;
    topup_pending = 1'b0;
    topup_left = cap_limit(TOPUP_TICKS_RESET);
    first_fill_finished = 1'b0;
    first_fill_active = 1'b0;
    first_fill_elapsed = '0;
  endfunction

  // Advance the predicted state by one tick and return what the block should report.
  function automatic out_item_t predict_fill_tick(input in_item_t t);
    out_item_t r;
    logic owed;
    r = '0;
    if (t.power_on) begin
      owed = first_fill_en && !first_fill_finished;
      if (t.motor_starting) begin
        if (owed) first_fill_active = 1'b1;
      end else if (first_fill_active) begin
        // Forced first fill: valve open for the set length, then a done pulse.
        if (first_fill_elapsed < cap_limit(first_fill_len)) begin
          first_fill_elapsed++;
          r.valve_open = 1'b1;
        end else begin
          first_fill_finished = 1'b1;
          r.initial_fill_done = 1'b1;
          first_fill_active = 1'b0;
          first_fill_elapsed = '0;
        end
      end else begin
        if (topup_left != 0) begin
          topup_left--;
          r.valve_open = 1'b1;
        end
        // Debounce the level switch.
        if (t.sensor_wet) begin
          dry_run = '0;
          if (wet_run < cap_limit(detect_lim)) wet_run++;
          else level_q = 1'b1;
        end else begin
          wet_run = '0;
          if (dry_run < cap_limit(undetect_lim)) dry_run++;
          else level_q = 1'b0;
        end
        // Level actions, skipped only when every fault bit is set.
        if (t.fault_flags != ALL_FAULTS) begin
          if (level_q) begin
            if (topup_pending && t.setting_idle && !t.memento_shown) begin
              topup_pending = 1'b0;
              if (topup_left == 0) topup_left = cap_limit(topup_len);
            end
          end else begin
            if (t.wash_mode) begin
              r.request_wash_stop = 1'b1;
            end else begin
              if (!topup_pending) r.request_homing = 1'b1;
              if (t.motors_home && !t.sterilizing && !t.nozzle_cleaning && topup_left == 0 &&
                  !t.memento_shown && !t.factory_running && !t.stop_error) begin
                r.valve_open = 1'b1;
              end
            end
            r.electrolysis_stop = 1'b1;
            topup_pending = 1'b1;
          end
        end
      end
    end
    r.level_present = level_q;
    return r;
  endfunction

  function automatic string show_result(input out_item_t r);
    return $sformatf("valve=%b level=%b wash_stop=%b homing=%b ew_stop=%b fill_done=%b",
                     r.valve_open, r.level_present, r.request_wash_stop, r.request_homing,
                     r.electrolysis_stop, r.initial_fill_done);
  endfunction

  // Flags are setting_idle, memento, wash, motors_home, sterilizing, nozzle, factory,
  // stop_error from the top bit down.
  function automatic in_item_t make_tick(input logic pw, input logic ms, input logic wet,
                                         input logic [FAULT_WIDTH-1:0] faults,
                                         input logic [7:0] flags);
    in_item_t t;
    t.power_on = pw;
    t.motor_starting = ms;
    t.sensor_wet = wet;
    t.fault_flags = faults;
    {t.setting_idle, t.memento_shown, t.wash_mode, t.motors_home, t.sterilizing,
     t.nozzle_cleaning, t.factory_running, t.stop_error} = flags;
    return t;
  endfunction

  // Random tick: the sensor holds steady for runs so the debounce can settle, with
  // an odd blip; the flags lean toward the case where a low level opens the valve.
  function automatic in_item_t random_tick();
    in_item_t t;
    if (sensor_run_left == 0) begin
      sensor_now = 1'($urandom_range(0, 1));
      sensor_run_left = $urandom_range(1, sensor_run_max);
    end
    sensor_run_left--;
    t.power_on = ($urandom_range(0, 15) != 0);
    t.motor_starting = ($urandom_range(0, motor_odds - 1) == 0);
    t.sensor_wet = ($urandom_range(0, 19) == 0) ? !sensor_now : sensor_now;
    t.fault_flags = ($urandom_range(0, 7) == 0) ? ALL_FAULTS :
                    FAULT_WIDTH'($urandom_range(0, 31));
    t.setting_idle = ($urandom_range(0, 3) != 0);
    t.memento_shown = ($urandom_range(0, 4) == 0);
    t.wash_mode = ($urandom_range(0, 2) == 0);
    t.motors_home = ($urandom_range(0, 4) != 0);
    t.sterilizing = ($urandom_range(0, 4) == 0);
    t.nozzle_cleaning = ($urandom_range(0, 4) == 0);
    t.factory_running = ($urandom_range(0, 4) == 0);
    t.stop_error = ($urandom_range(0, 4) == 0);
    return t;
  endfunction

  // Offer one tick and wait for its transfer; valid stays high into the next tick
  // unless a gap is due.
  task automatic send_tick(input in_item_t t);
    if (pace_sender && burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (burst_left != 0) burst_left--;
  endtask

  task automatic send_random(input int n);
    repeat (n) send_tick(random_tick());
  endtask

  // Stop offering ticks until every owed result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (fill_results_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input limit_t val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_DETECT_TICKS: detect_lim = val;
      CFG_UNDETECT_TICKS: undetect_lim = val;
      CFG_TOPUP_TICKS: topup_len = val;
      CFG_INITIAL_FILL_TICKS: first_fill_len = val;
      CFG_INITIAL_FILL_ENABLE: begin
        first_fill_en = val[0];
        first_fill_finished = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic apply_settings(input limit_t det, input limit_t undet, input limit_t topup,
                                input limit_t fill, input limit_t fill_en);
    write_reg(CFG_DETECT_TICKS, det);
    write_reg(CFG_UNDETECT_TICKS, undet);
    write_reg(CFG_TOPUP_TICKS, topup);
    write_reg(CFG_INITIAL_FILL_TICKS, fill);
    write_reg(CFG_INITIAL_FILL_ENABLE, fill_en);
    cfg_we <= 1'b0;
  endtask

  // Power off, motor start, the fault gate and the low level actions at reset settings.
  task automatic test_directed_basics();
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 5'h00, 8'h00));
    send_tick(make_tick(1'b0, 1'b1, 1'b1, 5'h1F, 8'hFF));
    send_tick(make_tick(1'b1, 1'b1, 1'b1, 5'h1F, 8'hFF));
    send_tick(make_tick(1'b1, 1'b0, 1'b1, 5'h1F, 8'hFF));
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 5'h00, 8'h00));
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 5'h00, 8'h20));
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 5'h01, 8'h10));
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 5'h02, 8'h18));
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 5'h04, 8'h14));
    send_tick(make_tick(1'b1, 1'b0, 1'b1, 5'h08, 8'h12));
    send_tick(make_tick(1'b1, 1'b0, 1'b1, 5'h10, 8'h11));
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 5'h1E, 8'hC0));
  endtask

  // Forced first fill: arming, the valve run, the done pulse, a zero length and a
  // disable written with the upper data bits set.
  task automatic test_first_fill();
    drain_results();
    apply_settings(16'd2, 16'd2, 16'd0, 16'd3, 16'd1);
    send_tick(make_tick(1'b1, 1'b1, 1'b0, 5'h00, 8'h10));
    repeat (4) send_tick(make_tick(1'b1, 1'b0, 1'b1, 5'h00, 8'h90));
    send_tick(make_tick(1'b1, 1'b1, 1'b0, 5'h00, 8'h00));
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 5'h00, 8'h00));
    drain_results();
    write_reg(CFG_SPARE_INDEX, 16'hFFFF);
    apply_settings(16'd2, 16'd2, 16'd1, 16'd0, 16'd1);
    send_tick(make_tick(1'b1, 1'b1, 1'b1, 5'h00, 8'hFF));
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 5'h00, 8'h00));
    send_tick(make_tick(1'b1, 1'b0, 1'b1, 5'h00, 8'h00));
    send_tick(make_tick(1'b1, 1'b0, 1'b1, 5'h00, 8'h80));
    drain_results();
    apply_settings(16'd2, 16'd2, 16'd1, 16'd4, 16'hFFFE);
    send_tick(make_tick(1'b1, 1'b1, 1'b0, 5'h00, 8'h00));
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 5'h00, 8'h00));
  endtask

  // Short debounce and top-up lengths so the level moves often.
  task automatic test_debounce_and_topup();
    drain_results();
    apply_settings(16'd3, 16'd2, 16'd4, 16'd5, 16'd1);
    pace_sender = 1'b1;
    motor_odds = 16;
    sensor_run_max = 12;
    send_random(180);
    for (int p = 0; p < 3; p++) begin
      drain_results();
      apply_settings(limit_t'($urandom_range(0, 12)), limit_t'($urandom_range(0, 12)),
                     limit_t'($urandom_range(0, 12)), limit_t'($urandom_range(0, 12)),
                     limit_t'($urandom_range(0, 1)));
      pace_sender = (p != 1);
      motor_odds = $urandom_range(6, 24);
      sensor_run_max = 30;
      send_random(100);
    end
  endtask

  // Limits at both ends of their range.
  task automatic test_limit_extremes();
    drain_results();
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
    pace_sender = 1'b0;
    motor_odds = 8;
    sensor_run_max = 4;
    send_random(150);
    drain_results();
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd2, 16'd0);
    pace_sender = 1'b1;
    send_random(100);
    drain_results();
    apply_settings(16'd1, 16'd7, 16'd2, 16'hFFFF, 16'd1);
    send_random(60);
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    drain_results();
    apply_settings(16'd2, 16'd3, 16'd3, 16'd4, 16'd1);
    pace_sender = 1'b0;
    motor_odds = 12;
    sensor_run_max = 10;
    hold_request = 1'b1;
    send_random(135);
    drain_results();
  endtask

  // Record the predicted result of every tick transfer.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      fill_results_due.push_back(predict_fill_tick(in_ch.data));
    end
  end

  // Compare every result transfer with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (fill_results_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result: %s", show_result(out_ch.data));
      end else begin
        want = fill_results_due.pop_front();
        if (out_ch.data !== want) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("result mismatch:\n  expected %s\n  actual   %s",
                     show_result(want), show_result(out_ch.data));
          end
        end
      end
    end
  end

  // End the run if no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", stall_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Receiver: switches among ready patterns, with a long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_cycle == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_cycle = 64;
      end
      rx_cycle--;
      if (hold_request) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_ch.ready <= 1'b1;
          RX_MOSTLY: out_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_PERIODIC: out_ch.ready <= (rx_cycle % 5 != 0);
          default: out_ch.ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  initial begin
    clk = 1'b0;
    fail_count = 0;
    stall_cycles = 0;
    pace_sender = 1'b1;
    burst_left = 0;
    motor_odds = 16;
    sensor_run_max = 8;
    sensor_now = 1'b0;
    sensor_run_left = 0;
    rx_mode = RX_ALWAYS;
    rx_cycle = 0;
    hold_left = 0;
    hold_request = 1'b0;
    reset_fill_state();
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_basics();
    test_first_fill();
    test_debounce_and_topup();
    test_limit_extremes();
    test_backpressure();

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && fill_results_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
